### sv/tolerance_row_merge_unit_defines.svh
// Assertion macros shared by the tolerance row merge modules
`ifndef TOLERANCE_ROW_MERGE_UNIT_DEFINES_SVH
`define TOLERANCE_ROW_MERGE_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define TRM_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define TRM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/trm_pkg.sv
// Shared constants, types and command/status structs of the tolerance row merge unit
package trm_pkg;

  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLUMNS = 8;
  localparam int ROW_W       = 4;
  localparam int COL_W       = 3;
  localparam int ADDR_W      = ROW_W + COL_W;
  localparam int DIST_W      = 32;
  localparam int WGT_W       = 17;
  localparam int WSUM_W      = WGT_W + 1;
  localparam int CNT_W       = 5;
  localparam int RIU_W       = 5;
  localparam int CIU_W       = 4;
  localparam int LBL_W       = 4;
  localparam int SUM_W       = DIST_W + ROW_W;
  localparam int STEP_W      = $clog2(SUM_W);
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic [WGT_W-1:0] WEIGHT_ONE = WGT_W'(65536);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = CFG_IDX_W'(2);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD        = 2'd0,
    MODE_MERGE       = 2'd1,
    MODE_READ_MERGED = 2'd2,
    MODE_READ_LABEL  = 2'd3
  } mode_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  load_wr;
    logic  rd_latch;
    logic  push;
    mode_t resp_mode;
    logic  merge_init;
    logic  skip_i;
    logic  open_i;
    logic  close_group;
    logic  skip_j;
    logic  cmp_start;
    logic  cmp_issue;
    logic  decide;
    logic  form_done;
    logic  pass_start;
    logic  avg_issue;
    logic  div_start;
    logic  md_write;
  } trm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic i_end;
    logic i_last;
    logic i_claimed;
    logic j_end;
    logic j_claimed;
    logic c_last;
    logic g_end;
    logic div_busy;
    logic div_done;
  } trm_stat_t;

endpackage

### sv/tolerance_row_merge_unit.sv
// Top level of the tolerance row merge unit: controller, datapath and ports
//
// Channels: in_* carries one command per transfer (load element, run merge,
// read merged element, read row label); out_* carries one result for each
// merge and read command, none for a load; cfg_* writes tolerance,
// rows_in_use and columns_in_use by index and is always ready.
// A read latches the addressed entries at its transfer; a response state
// moves them into the output register once that register is free. A merge
// compares row pairs one column a cycle through the two read ports of the
// distance memory, and each column average of a group waits on a bit-serial
// divider. Commands are taken one at a time; a load or a new read may be
// taken while an earlier result still waits in the output register. When
// the receiver stalls, out_valid and the payload hold and a pending read
// waits there. Reset clears labels, merged tables, group count and
// configuration to its defaults; loaded distances and weights are undefined
// until written.
module tolerance_row_merge_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [trm_pkg::MODE_W-1:0]    in_mode,
  input  logic [trm_pkg::ROW_W-1:0]     in_row,
  input  logic [trm_pkg::COL_W-1:0]     in_column,
  input  logic [trm_pkg::DIST_W-1:0]    in_distance,
  input  logic [trm_pkg::WGT_W-1:0]     in_weight,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [trm_pkg::CNT_W-1:0]     out_group_count,
  output logic [trm_pkg::DIST_W-1:0]    out_merged_distance,
  output logic [trm_pkg::WGT_W-1:0]     out_merged_weight,
  output logic [trm_pkg::LBL_W-1:0]     out_group_label,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [trm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trm_pkg::DIST_W-1:0]    cfg_data
);
  import trm_pkg::*;

  trm_cmd_t  cmd;
  trm_stat_t st;
  logic      cfg_we;

  // Take configuration writes in any cycle
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  trm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  trm_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_row              (in_row),
    .in_column           (in_column),
    .in_distance         (in_distance),
    .in_weight           (in_weight),
    .out_group_count     (out_group_count),
    .out_merged_distance (out_merged_distance),
    .out_merged_weight   (out_merged_weight),
    .out_group_label     (out_group_label)
  );

endmodule

### sv/trm_divider.sv
// Bit-serial restoring divider for column sums over member counts
module trm_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [trm_pkg::SUM_W-1:0]  dividend,
  input  logic [trm_pkg::CNT_W-1:0]  divisor,
  output logic                       busy,
  output logic                       done,
  output logic [trm_pkg::SUM_W-1:0]  quotient
);
  import trm_pkg::*;

  logic [SUM_W-1:0]  acc_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [CNT_W:0]    rem_sub;

  // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_r, acc_r[SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  // Hold control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SUM_W - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          step_r <= step_r - STEP_W'(1);
        end
      end
    end
  end

  // Advance the shift register and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      acc_r <= {acc_r[SUM_W-2:0], ge};
      rem_r <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = acc_r;

endmodule

### sv/trm_ctrl.sv
// Controller state machine sequencing loads, reads and the greedy merge
`include "tolerance_row_merge_unit_defines.svh"

module trm_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [trm_pkg::MODE_W-1:0] in_mode,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  trm_pkg::trm_stat_t         st,
  output trm_pkg::trm_cmd_t          cmd
);
  import trm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN_I,
    ST_SCAN_J,
    ST_CMP,
    ST_CMP_WAIT,
    ST_DECIDE,
    ST_FORM_DONE,
    ST_AVG_START,
    ST_AVG_SCAN,
    ST_AVG_WAIT,
    ST_AVG_DIV,
    ST_DIV_WAIT,
    ST_RESP
  } state_t;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic   out_valid_r, out_valid_nxt;
  mode_t  in_mode_e;
  logic   in_xfer;

  assign in_mode_e = mode_t'(in_mode);
  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;

  // Decode next state and commands
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.resp_mode = mode_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          mode_nxt = in_mode_e;
          case (in_mode_e)
            MODE_LOAD:  cmd.load_wr = 1'b1;
            MODE_MERGE: state_nxt = ST_CLEAR;
            MODE_READ_MERGED, MODE_READ_LABEL: begin
              cmd.rd_latch = 1'b1;
              state_nxt    = ST_RESP;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.merge_init = 1'b1;
        state_nxt      = ST_SCAN_I;
      end
      // Walk opening rows
      ST_SCAN_I: begin
        if (st.i_end) begin
          state_nxt = ST_FORM_DONE;
        end else if (st.i_claimed) begin
          cmd.skip_i = 1'b1;
        end else begin
          cmd.open_i = 1'b1;
          state_nxt  = ST_SCAN_J;
        end
      end
      // Walk candidate rows after the opening row
      ST_SCAN_J: begin
        if (st.j_end) begin
          cmd.close_group = 1'b1;
          state_nxt       = ST_SCAN_I;
        end else if (st.j_claimed) begin
          cmd.skip_j = 1'b1;
        end else begin
          cmd.cmp_start = 1'b1;
          state_nxt     = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.cmp_issue = 1'b1;
        if (st.c_last) begin
          state_nxt = ST_CMP_WAIT;
        end
      end
      ST_CMP_WAIT: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = ST_SCAN_J;
      end
      ST_FORM_DONE: begin
        cmd.form_done = 1'b1;
        state_nxt     = ST_AVG_START;
      end
      // Average each group column by column
      ST_AVG_START: begin
        if (st.g_end) begin
          state_nxt = ST_RESP;
        end else begin
          cmd.pass_start = 1'b1;
          state_nxt      = ST_AVG_SCAN;
        end
      end
      ST_AVG_SCAN: begin
        cmd.avg_issue = 1'b1;
        if (st.i_last) begin
          state_nxt = ST_AVG_WAIT;
        end
      end
      ST_AVG_WAIT: state_nxt = ST_AVG_DIV;
      ST_AVG_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (st.div_done) begin
          cmd.md_write = 1'b1;
          state_nxt    = ST_AVG_START;
        end
      end
      // Hand the result to the output register once it is free
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.push      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `TRM_ASSERT_IMPL(a_div_start_idle, cmd.div_start, !st.div_busy, "divider started while busy")
  `TRM_ASSERT_NEXT(a_div_start_runs, cmd.div_start, st.div_busy, "divider did not start")

endmodule

### sv/trm_datapath.sv
// Datapath: tables, merge counters, difference and average arithmetic, output register
`include "tolerance_row_merge_unit_defines.svh"

module trm_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  trm_pkg::trm_cmd_t             cmd,
  output trm_pkg::trm_stat_t            st,
  input  logic                          cfg_we,
  input  logic [trm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trm_pkg::DIST_W-1:0]    cfg_data,
  input  logic [trm_pkg::ROW_W-1:0]     in_row,
  input  logic [trm_pkg::COL_W-1:0]     in_column,
  input  logic [trm_pkg::DIST_W-1:0]    in_distance,
  input  logic [trm_pkg::WGT_W-1:0]     in_weight,
  output logic [trm_pkg::CNT_W-1:0]     out_group_count,
  output logic [trm_pkg::DIST_W-1:0]    out_merged_distance,
  output logic [trm_pkg::WGT_W-1:0]     out_merged_weight,
  output logic [trm_pkg::LBL_W-1:0]     out_group_label
);
  import trm_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;

  // Configuration
  logic [DIST_W-1:0] tol_r;
  logic [RIU_W-1:0]  n_r;
  logic [CIU_W-1:0]  k_r;
  logic [RIU_W-1:0]  rows_req, rows_clamp;
  logic [CIU_W-1:0]  cols_req, cols_clamp;

  // Merge counters and flags
  logic [RIU_W-1:0]     i_r, j_r;
  logic [CIU_W-1:0]     c_r;
  logic [CNT_W-1:0]     g_r, groups_r;
  logic [MAX_ROWS-1:0]  claimed_r;
  logic [LBL_W-1:0]     label_r [MAX_ROWS];
  logic [WGT_W-1:0]     mw_r [MAX_ROWS];
  logic [DEPTH-1:0]     mdv_r;
  logic [WGT_W-1:0]     weight_r [MAX_ROWS];

  logic [ROW_W-1:0]  i_idx, j_idx, g_idx, lbl_addr;
  logic [COL_W-1:0]  c_idx;
  logic [LBL_W-1:0]  lbl_q;

  // Memories and read data
  logic [DIST_W-1:0] dist_mem [DEPTH];
  logic [DIST_W-1:0] md_mem [DEPTH];
  logic [DIST_W-1:0] rd_a_r, rd_b_r, md_q_r;

  // Arithmetic
  logic              cmp_vld_r, avg_vld_r, match_r;
  logic [ROW_W-1:0]  wrow_r;
  logic [DIST_W-1:0] diff, worst_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WSUM_W-1:0] wsum_r, wsum_add;
  logic [WGT_W-1:0]  w_clamp;

  // Read request and output payload
  logic              rd_mdv_r;
  logic [WGT_W-1:0]  rd_w_r;
  logic [LBL_W-1:0]  rd_lbl_r;
  logic [CNT_W-1:0]  out_gc_r;
  logic [DIST_W-1:0] out_md_r;
  logic [WGT_W-1:0]  out_mw_r;
  logic [LBL_W-1:0]  out_lbl_r;

  logic              div_busy, div_done;
  logic [SUM_W-1:0]  quotient;

  assign i_idx    = i_r[ROW_W-1:0];
  assign j_idx    = j_r[ROW_W-1:0];
  assign g_idx    = g_r[ROW_W-1:0];
  assign c_idx    = c_r[COL_W-1:0];
  assign lbl_addr = cmd.rd_latch ? in_row : i_idx;
  assign lbl_q    = label_r[lbl_addr];

  // Saturate row and column counts into range
  assign rows_req   = cfg_data[RIU_W-1:0];
  assign cols_req   = cfg_data[CIU_W-1:0];
  assign rows_clamp = (rows_req == '0) ? RIU_W'(1) :
                      (rows_req > RIU_W'(MAX_ROWS)) ? RIU_W'(MAX_ROWS) : rows_req;
  assign cols_clamp = (cols_req == '0) ? CIU_W'(1) :
                      (cols_req > CIU_W'(MAX_COLUMNS)) ? CIU_W'(MAX_COLUMNS) : cols_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
      n_r   <= RIU_W'(MAX_ROWS);
      k_r   <= CIU_W'(MAX_COLUMNS);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOLERANCE: tol_r <= cfg_data;
        CFG_ROWS:      n_r   <= rows_clamp;
        CFG_COLUMNS:   k_r   <= cols_clamp;
        default: ;
      endcase
    end
  end

  // Advance counters, claim rows and record labels and group weights
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r       <= '0;
      j_r       <= '0;
      c_r       <= '0;
      g_r       <= '0;
      groups_r  <= '0;
      claimed_r <= '0;
      label_r   <= '{default: '0};
      mw_r      <= '{default: '0};
      mdv_r     <= '0;
    end else begin
      if (cmd.merge_init) begin
        claimed_r <= '0;
        label_r   <= '{default: '0};
        mw_r      <= '{default: '0};
        mdv_r     <= '0;
        g_r       <= '0;
        i_r       <= '0;
      end
      if (cmd.skip_i) begin
        i_r <= i_r + RIU_W'(1);
      end
      if (cmd.open_i) begin
        claimed_r[i_idx] <= 1'b1;
        label_r[i_idx]   <= g_r[LBL_W-1:0];
        j_r              <= i_r + RIU_W'(1);
      end
      if (cmd.close_group) begin
        g_r <= g_r + CNT_W'(1);
        i_r <= i_r + RIU_W'(1);
      end
      if (cmd.skip_j) begin
        j_r <= j_r + RIU_W'(1);
      end
      if (cmd.cmp_start) begin
        c_r <= '0;
      end
      if (cmd.cmp_issue) begin
        c_r <= c_r + CIU_W'(1);
      end
      if (cmd.decide) begin
        if (worst_r <= tol_r) begin
          claimed_r[j_idx] <= 1'b1;
          label_r[j_idx]   <= g_r[LBL_W-1:0];
        end
        j_r <= j_r + RIU_W'(1);
      end
      if (cmd.form_done) begin
        groups_r <= g_r;
        g_r      <= '0;
        c_r      <= '0;
      end
      if (cmd.pass_start) begin
        i_r <= '0;
      end
      if (cmd.avg_issue) begin
        i_r <= i_r + RIU_W'(1);
      end
      if (cmd.div_start) begin
        mw_r[g_idx] <= wsum_r[WGT_W-1:0];
      end
      if (cmd.md_write) begin
        mdv_r[{g_idx, c_idx}] <= 1'b1;
        if (st.c_last) begin
          c_r <= '0;
          g_r <= g_r + CNT_W'(1);
        end else begin
          c_r <= c_r + CIU_W'(1);
        end
      end
    end
  end

  // Store loaded distances, read two rows for comparison or one for averaging
  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      dist_mem[{in_row, in_column}] <= in_distance;
    end
    rd_a_r <= dist_mem[{i_idx, c_idx}];
    rd_b_r <= dist_mem[{j_idx, c_idx}];
  end

  // Store row weights, clamped to one
  assign w_clamp = (in_weight > WEIGHT_ONE) ? WEIGHT_ONE : in_weight;

  always_ff @(posedge clk) begin
    if (cmd.load_wr && (in_column == '0)) begin
      weight_r[in_row] <= w_clamp;
    end
  end

  // Merged distance table
  always_ff @(posedge clk) begin
    if (cmd.md_write) begin
      md_mem[{g_idx, c_idx}] <= quotient[DIST_W-1:0];
    end
    if (cmd.rd_latch) begin
      md_q_r <= md_mem[{in_row, in_column}];
    end
  end

  // Track read data that is in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
      avg_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.cmp_issue;
      avg_vld_r <= cmd.avg_issue;
    end
  end

  always_ff @(posedge clk) begin
    match_r <= (lbl_q == g_r[LBL_W-1:0]);
    wrow_r  <= i_idx;
  end

  // Keep the largest column difference
  assign diff = (rd_a_r > rd_b_r) ? (rd_a_r - rd_b_r) : (rd_b_r - rd_a_r);

  always_ff @(posedge clk) begin
    if (cmd.cmp_start) begin
      worst_r <= '0;
    end else if (cmp_vld_r && (diff > worst_r)) begin
      worst_r <= diff;
    end
  end

  // Accumulate member sums, count and saturating weight
  assign wsum_add = wsum_r + WSUM_W'(weight_r[wrow_r]);

  always_ff @(posedge clk) begin
    if (cmd.pass_start) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      wsum_r <= '0;
    end else if (avg_vld_r && match_r) begin
      sum_r  <= sum_r + SUM_W'(rd_a_r);
      cnt_r  <= cnt_r + CNT_W'(1);
      wsum_r <= (wsum_add > WSUM_W'(WEIGHT_ONE)) ? WSUM_W'(WEIGHT_ONE) : wsum_add;
    end
  end

  trm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  // Capture the addressed entries of a read request
  always_ff @(posedge clk) begin
    if (cmd.rd_latch) begin
      rd_mdv_r <= mdv_r[{in_row, in_column}];
      rd_w_r   <= mw_r[in_row];
      rd_lbl_r <= lbl_q;
    end
  end

  // Output register, loaded on each result transfer into it
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_gc_r  <= groups_r;
      out_md_r  <= ((cmd.resp_mode == MODE_READ_MERGED) && rd_mdv_r) ? md_q_r : '0;
      out_mw_r  <= (cmd.resp_mode == MODE_READ_MERGED) ? rd_w_r : '0;
      out_lbl_r <= (cmd.resp_mode == MODE_READ_LABEL) ? rd_lbl_r : '0;
    end
  end

  assign out_group_count     = out_gc_r;
  assign out_merged_distance = out_md_r;
  assign out_merged_weight   = out_mw_r;
  assign out_group_label     = out_lbl_r;

  // Status to the controller
  assign st.i_end     = (i_r >= n_r);
  assign st.i_last    = (i_r == (n_r - RIU_W'(1)));
  assign st.i_claimed = claimed_r[i_idx];
  assign st.j_end     = (j_r >= n_r);
  assign st.j_claimed = claimed_r[j_idx];
  assign st.c_last    = (c_r == (k_r - CIU_W'(1)));
  assign st.g_end     = (g_r >= groups_r);
  assign st.div_busy  = div_busy;
  assign st.div_done  = div_done;

  `TRM_ASSERT_IMPL(a_open_unclaimed, cmd.open_i, !claimed_r[i_idx], "opened a claimed row")
  `TRM_ASSERT_IMPL(a_decide_unclaimed, cmd.decide, !claimed_r[j_idx], "compared a claimed row")
  `TRM_ASSERT_IMPL(a_group_nonempty, cmd.div_start, cnt_r != '0, "group has no members")

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the tolerance row merge unit
`timescale 1ns / 100ps

module testbench;
  import trm_pkg::*;

  // One command on the input channel
  typedef struct packed {
    mode_t             mode;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DIST_W-1:0] distance;
    logic [WGT_W-1:0]  wgt;
  } merge_cmd_t;

  // One result on the output channel
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [DIST_W-1:0] distance;
    logic [WGT_W-1:0]  wgt;
    logic [LBL_W-1:0]  label;
  } merge_reply_t;

  typedef enum logic {PLAN_CMD, PLAN_CONFIG} plan_kind_t;

  // One step of the directed part: a command, or a full register setting
  typedef struct packed {
    plan_kind_t   kind;
    logic         pinned;
    merge_cmd_t   cmd;
    merge_reply_t want;
    logic [31:0]  tol;
    logic [31:0]  rows;
    logic [31:0]  cols;
  } plan_row_t;

  localparam int ENTRIES = MAX_ROWS * MAX_COLUMNS;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [MODE_W-1:0]    in_mode = '0;
  logic [ROW_W-1:0]     in_row = '0;
  logic [COL_W-1:0]     in_column = '0;
  logic [DIST_W-1:0]    in_distance = '0;
  logic [WGT_W-1:0]     in_weight = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CNT_W-1:0]     out_group_count;
  logic [DIST_W-1:0]    out_merged_distance;
  logic [WGT_W-1:0]     out_merged_weight;
  logic [LBL_W-1:0]     out_group_label;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIST_W-1:0]    cfg_data = '0;

  tolerance_row_merge_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_row              (in_row),
    .in_column           (in_column),
    .in_distance         (in_distance),
    .in_weight           (in_weight),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_group_count     (out_group_count),
    .out_merged_distance (out_merged_distance),
    .out_merged_weight   (out_merged_weight),
    .out_group_label     (out_group_label),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // Predictor copy of registers and tables
  logic [DIST_W-1:0] tol_reg = '0;
  logic [RIU_W-1:0]  rows_reg = RIU_W'(MAX_ROWS);
  logic [CIU_W-1:0]  cols_reg = CIU_W'(MAX_COLUMNS);
  logic [DIST_W-1:0] dist_mem [ENTRIES];
  logic [WGT_W-1:0]  wgt_mem [MAX_ROWS];
  bit                loaded [ENTRIES];
  logic [LBL_W-1:0]  label_mem [MAX_ROWS];
  logic [DIST_W-1:0] mdist_mem [ENTRIES];
  logic [WGT_W-1:0]  mwgt_mem [MAX_ROWS];
  logic [CNT_W-1:0]  groups_made = '0;

  merge_reply_t results_due [$];
  plan_row_t    plan [$];
  int           errors = 0;
  int           cmds_sent = 0;
  bit           steady = 1'b0;

  // Content of the current random phase: row clusters around a few centers
  logic [DIST_W-1:0] centers [3];
  logic [DIST_W-1:0] spread;

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (errors < 50) $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic int eff_rows();
    if (rows_reg < 1) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return int'(rows_reg);
  endfunction

  function automatic int eff_cols();
    if (cols_reg < 1) return 1;
    if (cols_reg > MAX_COLUMNS) return MAX_COLUMNS;
    return int'(cols_reg);
  endfunction

  // Greedy grouping of the active rows, then weight sums and column averages
  function automatic void merge_rows();
    int                n, k, g, cnt;
    logic [DIST_W-1:0] a, b, d, worst;
    logic [WSUM_W-1:0] wsum;
    logic [SUM_W-1:0]  sums [MAX_COLUMNS];
    bit                taken [MAX_ROWS];
    n = eff_rows();
    k = eff_cols();
    for (int r = 0; r < MAX_ROWS; r++) begin
      label_mem[r] = '0;
      mwgt_mem[r] = '0;
      taken[r] = 1'b0;
    end
    for (int e = 0; e < ENTRIES; e++) mdist_mem[e] = '0;
    g = 0;
    for (int i = 0; i < n; i++) begin
      if (!taken[i]) begin
        taken[i] = 1'b1;
        label_mem[i] = LBL_W'(g);
        for (int j = i + 1; j < n; j++) begin
          if (!taken[j]) begin
            worst = '0;
            for (int c = 0; c < k; c++) begin
              a = dist_mem[i*MAX_COLUMNS+c];
              b = dist_mem[j*MAX_COLUMNS+c];
              d = (a > b) ? a - b : b - a;
              if (d > worst) worst = d;
            end
            if (worst <= tol_reg) begin
              taken[j] = 1'b1;
              label_mem[j] = LBL_W'(g);
            end
          end
        end
        g++;
      end
    end
    groups_made = CNT_W'(g);
    for (int grp = 0; grp < int'(groups_made); grp++) begin
      wsum = '0;
      cnt = 0;
      for (int c = 0; c < MAX_COLUMNS; c++) sums[c] = '0;
      for (int i = 0; i < n; i++) begin
        if (label_mem[i] == LBL_W'(grp)) begin
          cnt++;
          wsum = wsum + wgt_mem[i];
          if (wsum > WEIGHT_ONE) wsum = WEIGHT_ONE;
          for (int c = 0; c < k; c++) sums[c] = sums[c] + dist_mem[i*MAX_COLUMNS+c];
        end
      end
      mwgt_mem[grp] = WGT_W'(wsum);
      if (cnt != 0) begin
        for (int c = 0; c < k; c++)
          mdist_mem[grp*MAX_COLUMNS+c] = DIST_W'(sums[c] / SUM_W'(cnt));
      end
    end
  endfunction

  // Update the predictor with one accepted command and form its result
  function automatic void apply_cmd(input merge_cmd_t c, output bit has,
                                    output merge_reply_t r);
    int e;
    e = int'(c.row) * MAX_COLUMNS + int'(c.col);
    r = '0;
    has = (c.mode != MODE_LOAD);
    case (c.mode)
      MODE_LOAD: begin
        dist_mem[e] = c.distance;
        loaded[e] = 1'b1;
        if (c.col == '0) wgt_mem[c.row] = (c.wgt > WEIGHT_ONE) ? WEIGHT_ONE : c.wgt;
      end
      MODE_MERGE: merge_rows();
      MODE_READ_MERGED: begin
        r.distance = mdist_mem[e];
        r.wgt = mwgt_mem[c.row];
      end
      MODE_READ_LABEL: r.label = label_mem[c.row];
      default: ;
    endcase
    r.count = groups_made;
  endfunction

  // Drive one command, wait for its transfer, then record what it should return
  task automatic send_cmd(input merge_cmd_t c, input bit pinned, input merge_reply_t want);
    bit           has;
    merge_reply_t pred;
    if (!steady) begin
      while ($urandom_range(99) < 21) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    in_mode     <= c.mode;
    in_row      <= c.row;
    in_column   <= c.col;
    in_distance <= c.distance;
    in_weight   <= c.wgt;
    do @(posedge clk); while (!in_ready);
    apply_cmd(c, has, pred);
    if (has) results_due.push_back(pinned ? want : pred);
    cmds_sent++;
  endtask

  task automatic send(input merge_cmd_t c);
    send_cmd(c, 1'b0, '0);
  endtask

  // Hold off until every result is back and any trailing load has finished
  task automatic settle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] tol, input logic [31:0] rows,
                            input logic [31:0] cols);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TOLERANCE;
    cfg_data  <= tol;
    do @(posedge clk); while (!cfg_ready);
    tol_reg = tol;
    cfg_index <= CFG_ROWS;
    cfg_data  <= rows;
    do @(posedge clk); while (!cfg_ready);
    rows_reg = rows[RIU_W-1:0];
    cfg_index <= CFG_COLUMNS;
    cfg_data  <= cols;
    do @(posedge clk); while (!cfg_ready);
    cols_reg = cols[CIU_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  function automatic plan_row_t cmd_row(input mode_t m, input int r, input int col,
                                        input logic [31:0] distance, input logic [16:0] wgt);
    plan_row_t p;
    p = '0;
    p.kind = PLAN_CMD;
    p.cmd.mode = m;
    p.cmd.row = ROW_W'(r);
    p.cmd.col = COL_W'(col);
    p.cmd.distance = distance;
    p.cmd.wgt = wgt;
    return p;
  endfunction

  function automatic plan_row_t pinned_row(input mode_t m, input int r, input int col,
                                           input logic [4:0] cnt, input logic [31:0] md,
                                           input logic [16:0] mw, input logic [3:0] lbl);
    plan_row_t p;
    p = cmd_row(m, r, col, '0, '0);
    p.pinned = 1'b1;
    p.want.count = cnt;
    p.want.distance = md;
    p.want.wgt = mw;
    p.want.label = lbl;
    return p;
  endfunction

  function automatic plan_row_t config_row(input logic [31:0] tol, input logic [31:0] rows,
                                           input logic [31:0] cols);
    plan_row_t p;
    p = '0;
    p.kind = PLAN_CONFIG;
    p.tol = tol;
    p.rows = rows;
    p.cols = cols;
    return p;
  endfunction

  // Load of one element, clustered around the phase centers with some outliers
  function automatic merge_cmd_t random_load(input int r, input int col);
    merge_cmd_t c;
    int         pick;
    c.mode = MODE_LOAD;
    c.row = ROW_W'(r);
    c.col = COL_W'(col);
    if ($urandom_range(0, 9) == 0) c.distance = $urandom;
    else c.distance = centers[$urandom_range(0, 2)] - (spread >> 1) + $urandom_range(0, spread);
    pick = $urandom_range(0, 19);
    if (pick < 3) c.wgt = WGT_W'($urandom_range(65537, 131071));
    else if (pick < 5) c.wgt = WEIGHT_ONE;
    else if (pick == 5) c.wgt = '0;
    else c.wgt = WGT_W'($urandom_range(0, 65536));
    return c;
  endfunction

  // Load every active element not yet written, so a merge reads only known data
  task automatic fill_rows(input int n, input int k);
    for (int r = 0; r < n; r++) begin
      for (int col = 0; col < k; col++) begin
        if (!loaded[r*MAX_COLUMNS+col]) send(random_load(r, col));
      end
    end
  endtask

  // One random phase: new register setting, then loads, merges and reads
  task automatic run_phase(input int phase_no);
    logic [31:0] tol, rows_v, cols_v;
    merge_cmd_t  c;
    int          n, k, ops, merges, pick, top;
    bit          big;
    big = (phase_no % 5 == 4);
    spread = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000);
    for (int i = 0; i < 3; i++) centers[i] = ($urandom_range(0, 7) == 0) ? '0 : $urandom;
    pick = $urandom_range(0, 5);
    if (pick == 0) tol = '0;
    else if (pick == 1) tol = 32'hFFFF_FFFF;
    else if (pick == 2) tol = $urandom;
    else if (pick == 3) tol = spread >> 1;
    else tol = $urandom_range(0, spread);
    if (phase_no == 4) begin
      tol = 32'hFFFF_FFFF;
      rows_v = 31;
      cols_v = 15;
    end else if (phase_no == 9) begin
      tol = '0;
      rows_v = MAX_ROWS;
      cols_v = MAX_COLUMNS;
    end else if (big) begin
      rows_v = $urandom_range(9, 31);
      cols_v = $urandom_range(4, 15);
    end else begin
      rows_v = $urandom_range(0, 6);
      cols_v = $urandom_range(0, 3);
    end
    // upper data bits beyond the register width are dropped
    if ($urandom_range(0, 3) == 0) rows_v = rows_v | ($urandom & ~32'h1F);
    if ($urandom_range(0, 3) == 0) cols_v = cols_v | ($urandom & ~32'hF);
    set_config(tol, rows_v, cols_v);
    n = eff_rows();
    k = eff_cols();
    ops = $urandom_range(30, 70);
    merges = 0;
    for (int op = 0; op < ops; op++) begin
      pick = $urandom_range(0, 99);
      c = '0;
      c.distance = $urandom;
      c.wgt = WGT_W'($urandom_range(0, 131071));
      c.col = COL_W'($urandom_range(0, MAX_COLUMNS - 1));
      top = (groups_made == 0) ? 0 : int'(groups_made) - 1;
      if (pick < 45) begin
        if ($urandom_range(0, 3) != 0) c = random_load($urandom_range(0, n - 1),
                                                       $urandom_range(0, k - 1));
        else c = random_load($urandom_range(0, MAX_ROWS - 1),
                             $urandom_range(0, MAX_COLUMNS - 1));
      end else if (pick < 53 && merges < (big ? 2 : 6)) begin
        fill_rows(n, k);
        c.mode = MODE_MERGE;
        c.row = ROW_W'($urandom_range(0, MAX_ROWS - 1));
        merges++;
      end else if (pick < 78) begin
        c.mode = MODE_READ_MERGED;
        c.row = ($urandom_range(0, 2) != 0) ? ROW_W'($urandom_range(0, top))
                                            : ROW_W'($urandom_range(0, MAX_ROWS - 1));
      end else begin
        c.mode = MODE_READ_LABEL;
        c.row = ROW_W'($urandom_range(0, MAX_ROWS - 1));
      end
      send(c);
    end
  endtask

  // Check each result against the oldest one due
  always @(posedge clk) begin
    merge_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        flag_mismatch("result with none due", out_group_count, '0);
      end else begin
        want = results_due.pop_front();
        if (out_group_count !== want.count)
          flag_mismatch("group_count", out_group_count, want.count);
        if (out_merged_distance !== want.distance)
          flag_mismatch("merged_distance", out_merged_distance, want.distance);
        if (out_merged_weight !== want.wgt)
          flag_mismatch("merged_weight", out_merged_weight, want.wgt);
        if (out_group_label !== want.label)
          flag_mismatch("group_label", out_group_label, want.label);
      end
    end
  end

  // Random receiver stalls, none during steady phases
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 21);
  end

  initial begin
    int wait_cycles;
    int phase_no;
    for (int e = 0; e < ENTRIES; e++) begin
      dist_mem[e] = '0;
      mdist_mem[e] = '0;
      loaded[e] = 1'b0;
    end
    for (int r = 0; r < MAX_ROWS; r++) begin
      wgt_mem[r] = '0;
      label_mem[r] = '0;
      mwgt_mem[r] = '0;
    end

    // Reads before any merge, smallest table with saturated low registers,
    // then a small three-row table with two groups
    plan.push_back(pinned_row(MODE_READ_LABEL, 0, 0, 0, 0, 0, 0));
    plan.push_back(pinned_row(MODE_READ_MERGED, 15, 7, 0, 0, 0, 0));
    plan.push_back(config_row(32'h0, 32'h0, 32'h0));
    plan.push_back(cmd_row(MODE_LOAD, 0, 0, 32'hFFFF_FFFF, 17'h1FFFF));
    plan.push_back(pinned_row(MODE_MERGE, 0, 0, 1, 0, 0, 0));
    plan.push_back(pinned_row(MODE_READ_MERGED, 0, 0, 1, 32'hFFFF_FFFF, 17'h10000, 0));
    plan.push_back(pinned_row(MODE_READ_MERGED, 0, 1, 1, 0, 17'h10000, 0));
    plan.push_back(pinned_row(MODE_READ_MERGED, 1, 0, 1, 0, 0, 0));
    plan.push_back(pinned_row(MODE_READ_LABEL, 5, 0, 1, 0, 0, 0));
    plan.push_back(config_row(32'h0001_0000, 32'd3, 32'd2));
    plan.push_back(cmd_row(MODE_LOAD, 0, 0, 32'h0001_0000, 17'h10000));
    plan.push_back(cmd_row(MODE_LOAD, 0, 1, 32'h0, 17'h1FFFF));
    plan.push_back(cmd_row(MODE_LOAD, 1, 0, 32'h0002_0000, 17'd40000));
    plan.push_back(cmd_row(MODE_LOAD, 1, 1, 32'h0000_8000, 17'h0));
    plan.push_back(cmd_row(MODE_LOAD, 2, 0, 32'h0002_0001, 17'h1));
    plan.push_back(cmd_row(MODE_LOAD, 2, 1, 32'h0, 17'h0));
    plan.push_back(cmd_row(MODE_MERGE, 0, 0, 32'h0, 17'h0));
    plan.push_back(cmd_row(MODE_READ_MERGED, 0, 0, 32'h0, 17'h0));
    plan.push_back(cmd_row(MODE_READ_MERGED, 0, 1, 32'h0, 17'h0));
    plan.push_back(cmd_row(MODE_READ_MERGED, 1, 0, 32'h0, 17'h0));
    plan.push_back(cmd_row(MODE_READ_LABEL, 1, 0, 32'h0, 17'h0));
    plan.push_back(cmd_row(MODE_READ_LABEL, 2, 0, 32'h0, 17'h0));
    plan.push_back(cmd_row(MODE_LOAD, 7, 7, 32'h5555_AAAA, 17'h0AAAA));
    plan.push_back(cmd_row(MODE_READ_LABEL, 15, 0, 32'h0, 17'h0));
    plan.push_back(cmd_row(MODE_MERGE, 0, 0, 32'h0, 17'h0));
    plan.push_back(cmd_row(MODE_READ_MERGED, 1, 1, 32'h0, 17'h0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[p]) begin
      if (plan[p].kind == PLAN_CONFIG) set_config(plan[p].tol, plan[p].rows, plan[p].cols);
      else send_cmd(plan[p].cmd, plan[p].pinned, plan[p].want);
    end

    // Random phases; a few in the middle run with no stalls on either side
    phase_no = 0;
    while (cmds_sent < 1950) begin
      steady = (phase_no >= 12 && phase_no < 16);
      run_phase(phase_no);
      phase_no++;
    end
    steady = 1'b0;

    // Drain, bounded well above the longest merge
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (results_due.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (results_due.size() != 0) flag_mismatch("results never delivered", results_due.size(), 0);
    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

  // Watchdog: 50 ms
  initial begin
    #50_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/trm_pkg.sv
sv/trm_divider.sv
sv/trm_ctrl.sv
sv/trm_datapath.sv
sv/tolerance_row_merge_unit.sv
tb/sv/testbench.sv
